FILE: hdl/rch_pkg.sv
// shared types, constants and trig tables of the ray coherence hash unit
// no dependencies; used by rch_front, rch_cell and ray_coherence_hash_unit
`default_nettype none

package rch_pkg;

  // spherical bucket bits per angle
  localparam int unsigned ANGLE_BITS = 3;
  localparam int unsigned DEG_SHIFT  = 8 - ANGLE_BITS;
  localparam int unsigned HASH_W     = 51;
  localparam int unsigned GRID_MAX   = 16;
  localparam int unsigned CELL_COUNT = GRID_MAX;
  localparam int unsigned SEARCH_STEPS = 8;

  // pi/180 in Q30 and the Taylor term count of the cosine build
  localparam logic [63:0] DEG_Q30      = 64'd18740330;
  localparam int unsigned TAYLOR_TERMS = 10;
  localparam logic [63:0] HALF_RANGE   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SAT_MAG      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MIN_X  = 3'd0,
    REG_MIN_Y  = 3'd1,
    REG_MIN_Z  = 3'd2,
    REG_MAX_X  = 3'd3,
    REG_MAX_Y  = 3'd4,
    REG_MAX_Z  = 3'd5,
    REG_FHBITS = 3'd6,
    REG_GBITS  = 3'd7
  } cfg_reg_e;

  typedef logic signed [31:0] trig_tab_t [256];

  // work carried from cell to cell
  typedef struct packed {
    logic [2:0][63:0]    rem;
    logic [2:0][63:0]    den;
    logic [2:0][15:0]    quo;
    logic [2:0]          zero;
    logic [2:0]          full;
    logic [HASH_W-1:0]   fhash;
    logic signed [31:0]  pz;
    logic [7:0]          tcnt;
    logic signed [25:0]  au;
    logic signed [25:0]  av;
    logic [7:0]          pcnt;
    logic                az_sp;
    logic [8:0]          az_val;
  } rch_work_t;

  // cosine in Q30 by a truncated Taylor series, elaboration only
  function automatic logic [63:0] cos_q30(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = 64'(k) * DEG_Q30;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    for (int unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic trig_tab_t build_cos();
    trig_tab_t t;
    for (int unsigned k = 0; k < 256; k++) begin
      if (k <= 90) t[k] = 32'(cos_q30(k));
      else if (k <= 180) t[k] = 32'(64'd0 - cos_q30(180 - k));
      else t[k] = '0;
    end
    return t;
  endfunction

  function automatic trig_tab_t build_sin();
    trig_tab_t t;
    for (int unsigned k = 0; k < 256; k++) begin
      if (k <= 90) t[k] = 32'(cos_q30(90 - k));
      else if (k <= 180) t[k] = 32'(cos_q30(k - 90));
      else t[k] = '0;
    end
    return t;
  endfunction

  localparam trig_tab_t COS_TAB = build_cos();
  localparam trig_tab_t SIN_TAB = build_sin();

endpackage

`default_nettype wire

FILE: hdl/rch_front.sv
// front stage: float-bit hash, biased fixed-point grid operands, polar z and
// aligned azimuth components; depends on rch_pkg
`default_nettype none

module rch_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [31:0]      origin_x_i,
  input  wire logic [31:0]      origin_y_i,
  input  wire logic [31:0]      origin_z_i,
  input  wire logic [31:0]      dir_x_i,
  input  wire logic [31:0]      dir_y_i,
  input  wire logic [31:0]      dir_z_i,
  input  wire logic [2:0][31:0] bmin_i,
  input  wire logic [2:0][31:0] bmax_i,
  input  wire logic [3:0]       fh_bits_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      rch_pkg::rch_work_t work_o
);
  import rch_pkg::*;

  // Q31.32 offset by 2^63 so unsigned order is numeric order
  function automatic logic [63:0] to_biased(input logic [31:0] b);
    logic [7:0]  e;
    logic [63:0] m;
    logic [63:0] mag;
    e = b[30:23];
    m = {40'd0, 1'b1, b[22:0]};
    if (e == 8'd0) mag = '0;
    else if (e >= 8'd158) mag = SAT_MAG;
    else if (e >= 8'd118) mag = m << (e - 8'd118);
    else mag = m >> (8'd118 - e);
    return b[31] ? HALF_RANGE - mag : HALF_RANGE + mag;
  endfunction

  function automatic logic [16:0] fhash(input logic [31:0] b, input logic [3:0] n);
    logic [7:0] mask;
    logic [7:0] ex;
    logic [7:0] mt;
    mask = 8'((9'd1 << n) - 9'd1);
    ex   = 8'(b >> (5'd31 - 5'(n))) & mask;
    mt   = 8'(b >> (5'd23 - 5'(n))) & mask;
    return (17'(b[31]) << (2 * n)) | (17'(ex) << n) | 17'(mt);
  endfunction

  function automatic logic [7:0] eff_exp(input logic [31:0] b);
    return (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
  endfunction

  // negated aligned mantissa
  function automatic logic signed [25:0] neg_aligned(input logic [31:0] b,
                                                     input logic [7:0] top);
    logic [7:0]  sh;
    logic [25:0] m;
    sh = top - eff_exp(b);
    m  = {2'b00, (b[30:23] != 8'd0), b[22:0]};
    m  = (sh >= 8'd32) ? 26'd0 : (m >> sh);
    return b[31] ? $signed(m) : -$signed(m);
  endfunction

  logic              valid_q;
  rch_work_t         work_q, work_d;
  logic [3:0]        n;
  logic [4:0]        w;
  logic [63:0]       hd, ho;
  logic [2:0][31:0]  org;
  logic [2:0][63:0]  uo, ul, uh;
  logic [7:0]        ez, top;
  logic signed [31:0] zmag;
  logic signed [25:0] u, v;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign work_o      = work_q;
  assign org         = {origin_z_i, origin_y_i, origin_x_i};

  always_comb begin
    work_d = '0;

    // float-bit hash of both packs
    n  = (fh_bits_i < 4'd1) ? 4'd1 : ((fh_bits_i > 4'd8) ? 4'd8 : fh_bits_i);
    w  = 5'(2 * n + 1);
    hd = (64'(fhash(dir_z_i, n)) << (2 * w)) | (64'(fhash(dir_y_i, n)) << w) |
         64'(fhash(dir_x_i, n));
    ho = (64'(fhash(origin_x_i, n)) << (2 * w)) | (64'(fhash(origin_y_i, n)) << w) |
         64'(fhash(origin_z_i, n));
    work_d.fhash = HASH_W'(hd ^ ho);

    // grid operands per axis
    for (int a = 0; a < 3; a++) begin
      uo[a] = to_biased(org[a]);
      ul[a] = to_biased(bmin_i[a]);
      uh[a] = to_biased(bmax_i[a]);
      work_d.zero[a] = (uh[a] <= ul[a]) || (uo[a] <= ul[a]);
      work_d.rem[a]  = uo[a] - ul[a];
      work_d.den[a]  = uh[a] - ul[a];
      work_d.full[a] = work_d.rem[a] >= work_d.den[a];
    end

    // polar z in Q2.30, clamped
    ez = dir_z_i[30:23];
    if (ez == 8'd0) zmag = '0;
    else if (ez >= 8'd127) zmag = Q30_ONE;
    else if (ez >= 8'd120) zmag = 32'({8'd0, 1'b1, dir_z_i[22:0]} << (ez - 8'd120));
    else zmag = 32'({8'd0, 1'b1, dir_z_i[22:0]} >> (8'd120 - ez));
    work_d.pz = dir_z_i[31] ? -zmag : zmag;

    // azimuth components aligned to the larger exponent
    top = (eff_exp(dir_x_i) > eff_exp(dir_y_i)) ? eff_exp(dir_x_i) : eff_exp(dir_y_i);
    u   = neg_aligned(dir_x_i, top);
    v   = neg_aligned(dir_y_i, top);
    work_d.az_sp  = 1'b0;
    work_d.az_val = 9'd0;
    if (u == 26'sd0 && v == 26'sd0) begin
      work_d.az_sp  = 1'b1;
      work_d.az_val = 9'd180;
    end else if (v == 26'sd0 && u > 26'sd0) begin
      work_d.az_sp  = 1'b1;
      work_d.az_val = 9'd360;
    end else if (v <= 26'sd0) begin
      work_d.az_val = 9'd180;
      u = -u;
      v = -v;
    end
    work_d.au = u;
    work_d.av = v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rch_cell.sv
// one cell: restoring division step per axis if step < grid_bits, and
// if step < 8 a binary polar/azimuth search step; depends on rch_pkg
`default_nettype none

module rch_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [3:0]        step_i,
  input  wire logic [4:0]        grid_bits_i,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire rch_pkg::rch_work_t work_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      rch_pkg::rch_work_t work_o
);
  import rch_pkg::*;

  logic               valid_q;
  rch_work_t          work_q, work_d;
  logic [63:0]        r2;
  logic [7:0]         bit_sel, tt, tp;
  logic signed [57:0] pa, pb;
  logic signed [58:0] df;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign work_o      = work_q;

  always_comb begin
    work_d = work_i;

    // division step while this cell is within the grid bit count
    for (int a = 0; a < 3; a++) begin
      r2 = work_i.rem[a] << 1;
      if (5'(step_i) < grid_bits_i) begin
        if (work_i.rem[a][63] || r2 >= work_i.den[a]) begin
          work_d.rem[a] = r2 - work_i.den[a];
          work_d.quo[a] = {work_i.quo[a][14:0], 1'b1};
        end else begin
          work_d.rem[a] = r2;
          work_d.quo[a] = {work_i.quo[a][14:0], 1'b0};
        end
      end
    end

    // binary search over degrees, top bit first
    bit_sel = 8'd128 >> step_i[2:0];
    tt = work_i.tcnt | bit_sel;
    tp = work_i.pcnt | bit_sel;
    pa = COS_TAB[tp] * work_i.av;
    pb = SIN_TAB[tp] * work_i.au;
    df = 59'(pa) - 59'(pb);
    if (step_i < 4'(SEARCH_STEPS)) begin
      if (tt <= 8'd180 && work_i.pz <= COS_TAB[tt]) work_d.tcnt = tt;
      if (tp <= 8'd179 && df >= 59'sd0) work_d.pcnt = tp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ray_coherence_hash_unit.sv
// Ray coherence hash unit: takes one ray per cycle while the output side does
// not stall and returns a 51-bit hash (float-bit hash ^ origin grid cell ^
// spherical direction bucket). The unit is a fully pipelined chain: one front
// stage, sixteen cells and an output register, so a new ray is accepted every
// cycle while the output side never stalls. Each of the sixteen cells
// performs one grid division step (up to grid_bits steps) and, in the first
// eight, one binary search step over the cos/sin degree tables. Each stage
// stalls only if its successor is full, so bubbles are squeezed out while a
// result waits. Configuration is written through its own port, always ready,
// and must only change while idle.
// Depends on rch_pkg, rch_front and rch_cell.
`default_nettype none

module ray_coherence_hash_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [31:0] origin_x_i,
  input  wire logic [31:0] origin_y_i,
  input  wire logic [31:0] origin_z_i,
  input  wire logic [31:0] dir_x_i,
  input  wire logic [31:0] dir_y_i,
  input  wire logic [31:0] dir_z_i,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [50:0] ray_hash_o
);
  import rch_pkg::*;

  logic [2:0][31:0] bmin_q, bmax_q;
  logic [3:0]       fh_bits_q;
  logic [4:0]       grid_bits_q;
  logic [4:0]       gs;

  // stage links: index 0 is the front stage output
  logic      lnk_valid [CELL_COUNT+1];
  logic      lnk_ready [CELL_COUNT+1];
  rch_work_t lnk_work  [CELL_COUNT+1];

  logic             out_valid_q;
  logic [50:0]      hash_q, hash_d;
  logic             fin_ready;
  rch_work_t        fw;
  logic [2:0][15:0] cell_idx;
  logic [8:0]       phi;
  logic [63:0]      hg, hs;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bmin_q      <= '0;
      bmax_q      <= {3{32'h3F80_0000}};
      fh_bits_q   <= 4'd4;
      grid_bits_q <= 5'd5;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MIN_X:  bmin_q[0]   <= cfg_data_i;
        REG_MIN_Y:  bmin_q[1]   <= cfg_data_i;
        REG_MIN_Z:  bmin_q[2]   <= cfg_data_i;
        REG_MAX_X:  bmax_q[0]   <= cfg_data_i;
        REG_MAX_Y:  bmax_q[1]   <= cfg_data_i;
        REG_MAX_Z:  bmax_q[2]   <= cfg_data_i;
        REG_FHBITS: fh_bits_q   <= cfg_data_i[3:0];
        REG_GBITS:  grid_bits_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign gs = (grid_bits_q < 5'd1) ? 5'd1 :
              ((grid_bits_q > 5'(GRID_MAX)) ? 5'(GRID_MAX) : grid_bits_q);

  // front stage
  rch_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .origin_z_i  (origin_z_i),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .bmin_i      (bmin_q),
    .bmax_i      (bmax_q),
    .fh_bits_i   (fh_bits_q),
    .out_valid_o (lnk_valid[0]),
    .out_ready_i (lnk_ready[0]),
    .work_o      (lnk_work[0])
  );

  // chain of cells
  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    rch_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (4'(i)),
      .grid_bits_i (gs),
      .in_valid_i  (lnk_valid[i]),
      .in_ready_o  (lnk_ready[i]),
      .work_i      (lnk_work[i]),
      .out_valid_o (lnk_valid[i+1]),
      .out_ready_i (lnk_ready[i+1]),
      .work_o      (lnk_work[i+1])
    );
  end

  // final combine into the output register
  assign fin_ready = !out_valid_q || out_ready_i;
  assign lnk_ready[CELL_COUNT] = fin_ready;
  assign fw = lnk_work[CELL_COUNT];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (fw.zero[a]) cell_idx[a] = '0;
      else if (fw.full[a]) cell_idx[a] = 16'((17'd1 << gs) - 17'd1);
      else cell_idx[a] = fw.quo[a];
    end
    hg  = (64'(cell_idx[0]) << (2 * gs)) | (64'(cell_idx[1]) << gs) | 64'(cell_idx[2]);
    phi = fw.az_sp ? fw.az_val : fw.az_val + 9'(fw.pcnt);
    hs  = (64'(phi >> DEG_SHIFT) << ANGLE_BITS) | 64'(fw.tcnt >> DEG_SHIFT);
    hash_d = fw.fhash ^ HASH_W'(hg) ^ HASH_W'(hs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_ready) begin
      out_valid_q <= lnk_valid[CELL_COUNT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_ready && lnk_valid[CELL_COUNT]) begin
      hash_q <= hash_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ray_hash_o  = hash_q;

endmodule

`default_nettype wire
